### rtl/differential_drive_mixer_top_defines.svh
// ----------------------------------------------------------------------------
// differential drive mixer assertion macros
// shared property wrappers, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_MIXER_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DDM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ddm assertion failed");

// next-cycle implication
`define DDM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ddm assertion failed");

`else

`define DDM_ASSERT_NOW(label, ante, cons)
`define DDM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// types and codes shared by the differential drive mixer modules
// ----------------------------------------------------------------------------
package ddm_pkg;

   typedef enum logic [1:0] {
      MODE_OFF = 2'd0,
      MODE_FWD = 2'd1,
      MODE_REV = 2'd2
   } bridge_mode_type;

   typedef enum logic {
      CSR_WEAPON_SPEED = 1'b0,
      CSR_DEBOUNCE_MS  = 1'b1
   } csr_index_type;

   localparam int DUTY_W  = 8;
   localparam int DEB_W   = 16;
   localparam int TIME_W  = 32;
   localparam int AXIS_W  = 4;
   localparam int CSR_W   = 16;

   localparam logic [DUTY_W-1:0] WEAPON_SPEED_RST = 8'd200;
   localparam logic [DEB_W-1:0]  DEBOUNCE_RST     = 16'd300;
   localparam logic [DUTY_W-1:0] DUTY_MAX         = 8'd255;

   typedef struct packed {
      logic [AXIS_W-1:0] stick_x;
      logic [AXIS_W-1:0] stick_y;
      logic              stick_active;
      logic              pad_up;
      logic              pad_down;
      logic              pad_left;
      logic              pad_right;
   } drive_cmd_type;

   typedef struct packed {
      bridge_mode_type   left_mode;
      bridge_mode_type   right_mode;
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
   } wheel_out_type;

endpackage

### rtl/ddm_mix.sv
// ----------------------------------------------------------------------------
// ddm_mix
// arcade mixing of stick or d-pad into left and right bridge mode and duty
// ----------------------------------------------------------------------------
module ddm_mix #(
   parameter int FULL_SPEED = 255,
   parameter int AXIS_RANGE = 7
) (
   input  ddm_pkg::drive_cmd_type cmd,
   input  logic                   reversed,
   output ddm_pkg::wheel_out_type wheels
);
   import ddm_pkg::*;

   localparam int MAG_W   = $clog2(FULL_SPEED + 1) + 5;
   localparam int SPEED_W = (MAG_W > 10) ? MAG_W : 10;
   localparam int CODES   = 2 ** AXIS_W;

   localparam logic signed [SPEED_W-1:0] S_POS = SPEED_W'(FULL_SPEED);
   localparam logic signed [SPEED_W-1:0] S_NEG = -S_POS;

   logic signed [SPEED_W-1:0] axis_tbl [CODES];
   logic signed [SPEED_W-1:0] fwd;
   logic signed [SPEED_W-1:0] turn;
   logic signed [SPEED_W-1:0] sum_l;
   logic signed [SPEED_W-1:0] sum_r;
   logic signed [SPEED_W-1:0] pad_s;
   logic signed [SPEED_W-1:0] left_s;
   logic signed [SPEED_W-1:0] right_s;

   // axis lookup, one entry per 4-bit code
   for (genvar g = 0; g < CODES; g++) begin : g_axis
      localparam int Code    = (g < CODES / 2) ? g : g - CODES;
      localparam int AxisVal =
         ((Code + AXIS_RANGE) * 2 * FULL_SPEED) / (2 * AXIS_RANGE) - FULL_SPEED;
      assign axis_tbl[g] = SPEED_W'(AxisVal);
   end

   function automatic logic signed [SPEED_W-1:0] clamp_speed(
      input logic signed [SPEED_W-1:0] v
   );
      logic signed [SPEED_W-1:0] r;
      if (v > S_POS) begin
         r = S_POS;
      end else if (v < S_NEG) begin
         r = S_NEG;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic bridge_mode_type mode_of(input logic signed [SPEED_W-1:0] v);
      bridge_mode_type m;
      if (v > 0) begin
         m = MODE_FWD;
      end else if (v < 0) begin
         m = MODE_REV;
      end else begin
         m = MODE_OFF;
      end
      return m;
   endfunction

   function automatic logic [DUTY_W-1:0] duty_of(input logic signed [SPEED_W-1:0] v);
      logic [SPEED_W-1:0] mag;
      logic [DUTY_W-1:0]  d;
      mag = (v < 0) ? unsigned'(-v) : unsigned'(v);
      if (mag > SPEED_W'(DUTY_MAX)) begin
         d = DUTY_MAX;
      end else begin
         d = mag[DUTY_W-1:0];
      end
      return d;
   endfunction

   assign fwd   = axis_tbl[cmd.stick_y];
   assign turn  = axis_tbl[cmd.stick_x];
   assign sum_l = clamp_speed(fwd + turn);
   assign sum_r = clamp_speed(fwd - turn);
   assign pad_s = reversed ? S_NEG : S_POS;

   always_comb begin
      if (cmd.stick_active) begin
         left_s  = reversed ? -sum_l : sum_l;
         right_s = reversed ? -sum_r : sum_r;
      end else if (cmd.pad_up) begin
         left_s  = pad_s;
         right_s = pad_s;
      end else if (cmd.pad_down) begin
         left_s  = -pad_s;
         right_s = -pad_s;
      end else if (cmd.pad_left) begin
         left_s  = -pad_s;
         right_s = pad_s;
      end else if (cmd.pad_right) begin
         left_s  = pad_s;
         right_s = -pad_s;
      end else begin
         left_s  = '0;
         right_s = '0;
      end
   end

   assign wheels.left_mode  = mode_of(left_s);
   assign wheels.right_mode = mode_of(right_s);
   assign wheels.left_duty  = duty_of(left_s);
   assign wheels.right_duty = duty_of(right_s);

endmodule

### rtl/differential_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer_top
// Takes one controller poll per request on the req_ channel (valid/stall) and
// returns one bridge command on the rsp_ channel: left and right wheel mode
// and duty, weapon bridge levels and weapon duty.
// A request accepted is held in an input register, and its result is loaded
// into the output register once the output side is free; rsp_valid rises with
// that load, and the result is taken while rsp_stall is low.
// Throughput: one request per cycle unless rsp_stall holds a waiting result,
// set by the single pass of mixing logic between the input and output registers.
// Stall: when rsp_stall holds a waiting result, one more request is still
// taken into the input register; req_stall rises only once both are full.
// Reset clears both valid flags, drive and weapon reversal, weapon on and both
// press times, and loads weapon_speed 200 and debounce_ms 300.
// csr_ writes (index 0 weapon_speed, 1 debounce_ms) are taken at once.
// ----------------------------------------------------------------------------
`include "differential_drive_mixer_top_defines.svh"

module differential_drive_mixer_top #(
   parameter int FULL_SPEED = 255,
   parameter int AXIS_RANGE = 7
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [3:0]  req_stick_x,
   input  logic signed [3:0]  req_stick_y,
   input  logic               req_stick_active,
   input  logic               req_pad_up,
   input  logic               req_pad_down,
   input  logic               req_pad_left,
   input  logic               req_pad_right,
   input  logic               req_invert_button,
   input  logic               req_weapon_button,
   input  logic [31:0]        req_now_ms,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_left_mode,
   output logic [1:0]         rsp_right_mode,
   output logic [7:0]         rsp_left_duty,
   output logic [7:0]         rsp_right_duty,
   output logic               rsp_weapon_a,
   output logic               rsp_weapon_b,
   output logic [7:0]         rsp_weapon_duty
);
   import ddm_pkg::*;

   // configuration
   logic [DUTY_W-1:0] weapon_speed_ff;
   logic [DEB_W-1:0]  debounce_ff;

   // input register
   logic              s1_valid_ff;
   drive_cmd_type     s1_cmd_ff;
   logic              s1_invert_ff;
   logic              s1_weapon_ff;
   logic [TIME_W-1:0] s1_now_ff;

   // toggle state
   logic              drive_rev_ff;
   logic              weapon_rev_ff;
   logic              weapon_on_ff;
   logic [TIME_W-1:0] last_invert_ff;
   logic [TIME_W-1:0] last_weapon_ff;

   // output register
   logic              rsp_valid_ff;
   wheel_out_type     wheels_ff;
   logic              weapon_a_ff;
   logic              weapon_b_ff;
   logic [DUTY_W-1:0] weapon_duty_ff;

   logic              out_free;
   logic              advance;
   logic              req_take;
   logic              toggle_inv;
   logic              toggle_wpn;
   logic              weapon_on_in;
   logic              weapon_rev_in;
   logic [TIME_W-1:0] inv_elapsed;
   logic [TIME_W-1:0] wpn_elapsed;
   wheel_out_type     wheels_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // driving uses reversal as it stood before this request's buttons
   ddm_mix #(
      .FULL_SPEED (FULL_SPEED),
      .AXIS_RANGE (AXIS_RANGE)
   ) u_mix (
      .cmd      (s1_cmd_ff),
      .reversed (drive_rev_ff),
      .wheels   (wheels_in)
   );

   // debounce on wrapping elapsed time
   assign inv_elapsed   = s1_now_ff - last_invert_ff;
   assign wpn_elapsed   = s1_now_ff - last_weapon_ff;
   assign toggle_inv    = s1_invert_ff && (inv_elapsed > TIME_W'(debounce_ff));
   assign toggle_wpn    = s1_weapon_ff && (wpn_elapsed > TIME_W'(debounce_ff));
   assign weapon_on_in  = weapon_on_ff ^ toggle_wpn;
   assign weapon_rev_in = weapon_rev_ff ^ toggle_inv;

   always_ff @(posedge clock) begin
      if (reset) begin
         weapon_speed_ff <= WEAPON_SPEED_RST;
         debounce_ff     <= DEBOUNCE_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_WEAPON_SPEED: weapon_speed_ff <= csr_wdata[DUTY_W-1:0];
            CSR_DEBOUNCE_MS:  debounce_ff     <= csr_wdata[DEB_W-1:0];
            default:          weapon_speed_ff <= weapon_speed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff.stick_x      <= unsigned'(req_stick_x);
         s1_cmd_ff.stick_y      <= unsigned'(req_stick_y);
         s1_cmd_ff.stick_active <= req_stick_active;
         s1_cmd_ff.pad_up       <= req_pad_up;
         s1_cmd_ff.pad_down     <= req_pad_down;
         s1_cmd_ff.pad_left     <= req_pad_left;
         s1_cmd_ff.pad_right    <= req_pad_right;
         s1_invert_ff           <= req_invert_button;
         s1_weapon_ff           <= req_weapon_button;
         s1_now_ff              <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_rev_ff   <= 1'b0;
         weapon_rev_ff  <= 1'b0;
         weapon_on_ff   <= 1'b0;
         last_invert_ff <= '0;
         last_weapon_ff <= '0;
      end else if (advance) begin
         drive_rev_ff  <= drive_rev_ff ^ toggle_inv;
         weapon_rev_ff <= weapon_rev_in;
         weapon_on_ff  <= weapon_on_in;
         if (toggle_inv) begin
            last_invert_ff <= s1_now_ff;
         end
         if (toggle_wpn) begin
            last_weapon_ff <= s1_now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // weapon outputs use the state after this request's buttons
   always_ff @(posedge clock) begin
      if (advance) begin
         wheels_ff      <= wheels_in;
         weapon_a_ff    <= weapon_on_in && weapon_rev_in;
         weapon_b_ff    <= weapon_on_in && !weapon_rev_in;
         weapon_duty_ff <= weapon_on_in ? weapon_speed_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_mode   = wheels_ff.left_mode;
   assign rsp_right_mode  = wheels_ff.right_mode;
   assign rsp_left_duty   = wheels_ff.left_duty;
   assign rsp_right_duty  = wheels_ff.right_duty;
   assign rsp_weapon_a    = weapon_a_ff;
   assign rsp_weapon_b    = weapon_b_ff;
   assign rsp_weapon_duty = weapon_duty_ff;

   // drive and weapon reversal always toggle together
   `DDM_ASSERT_NOW(a_rev_match, 1'b1, drive_rev_ff == weapon_rev_ff)
   // a request leaving the input register always lands in the output register
   `DDM_ASSERT_NEXT(a_advance_lands, advance, rsp_valid_ff)
   // reversal holds unless a debounced press moves through
   `DDM_ASSERT_NEXT(a_rev_hold, !(advance && toggle_inv), $stable(drive_rev_ff))
   // stopped wheel never carries duty
   `DDM_ASSERT_NOW(a_left_off_zero, rsp_valid_ff && (wheels_ff.left_mode == MODE_OFF), wheels_ff.left_duty == '0)
   // weapon bridge never drives both sides
   `DDM_ASSERT_NOW(a_weapon_one_side, rsp_valid_ff, !(weapon_a_ff && weapon_b_ff))

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the differential drive mixer. A scoreboard keeps its
// own copy of the reversal, weapon and press-time state, predicts the bridge
// command of every accepted poll and checks the returned commands in order.
// A directed pass covers the d-pad priorities, stick extremes and debounce
// corners, then random phases run under changing register settings with
// random gaps on the request side and random stalls on the result side, save in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
   import ddm_pkg::*;

   localparam int FULL_SPEED      = 255;
   localparam int AXIS_RANGE      = 7;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASES          = 7;
   localparam int POLLS_PER_PHASE = 260;

   typedef struct {
      logic signed [3:0] stick_x;
      logic signed [3:0] stick_y;
      logic              stick_active;
      logic              pad_up;
      logic              pad_down;
      logic              pad_left;
      logic              pad_right;
      logic              invert_button;
      logic              weapon_button;
      logic [31:0]       now_ms;
   } drive_poll_type;

   typedef struct {
      logic [1:0] left_mode;
      logic [1:0] right_mode;
      logic [7:0] left_duty;
      logic [7:0] right_duty;
      logic       weapon_a;
      logic       weapon_b;
      logic [7:0] weapon_duty;
   } bridge_cmd_type;

   class drive_scoreboard_type;
      logic [7:0]     weapon_speed;
      logic [15:0]    debounce_ms;
      bit             drive_reversed;
      bit             weapon_on;
      bit             weapon_reversed;
      logic [31:0]    last_invert_ms;
      logic [31:0]    last_weapon_ms;
      bridge_cmd_type pending_cmds[$];
      int             errors;
      int             checked;
      int             reversals;
      int             weapon_toggles;
      int             stick_polls;
      int             pad_polls;

      function new();
         weapon_speed    = WEAPON_SPEED_RST;
         debounce_ms     = DEBOUNCE_RST;
         drive_reversed  = 0;
         weapon_on       = 0;
         weapon_reversed = 0;
         last_invert_ms  = '0;
         last_weapon_ms  = '0;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] value);
         if (idx == CSR_WEAPON_SPEED) begin
            weapon_speed = value[7:0];
         end else begin
            debounce_ms = value;
         end
      endfunction

      function int axis_speed(logic signed [3:0] a);
         int num;
         num = (int'(a) + AXIS_RANGE) * (2 * FULL_SPEED);
         return num / (2 * AXIS_RANGE) - FULL_SPEED;
      endfunction

      function int clamp_speed(int v);
         if (v > FULL_SPEED) return FULL_SPEED;
         if (v < -FULL_SPEED) return -FULL_SPEED;
         return v;
      endfunction

      function bridge_mode_type mode_of(int s);
         if (s > 0) return MODE_FWD;
         if (s < 0) return MODE_REV;
         return MODE_OFF;
      endfunction

      function logic [7:0] duty_of(int s);
         int m;
         m = (s < 0) ? -s : s;
         if (m > 255) m = 255;
         return m[7:0];
      endfunction

      function void note_request(drive_poll_type p);
         int             fwd;
         int             turn;
         int             left;
         int             right;
         int             s;
         logic [31:0]    gap;
         bridge_cmd_type cmd;
         if (p.stick_active) begin
            stick_polls++;
            fwd   = axis_speed(p.stick_y);
            turn  = axis_speed(p.stick_x);
            left  = clamp_speed(fwd + turn);
            right = clamp_speed(fwd - turn);
            if (drive_reversed) begin
               left  = -left;
               right = -right;
            end
         end else begin
            pad_polls++;
            s = drive_reversed ? -FULL_SPEED : FULL_SPEED;
            if (p.pad_up) begin
               left  = s;
               right = s;
            end else if (p.pad_down) begin
               left  = -s;
               right = -s;
            end else if (p.pad_left) begin
               left  = -s;
               right = s;
            end else if (p.pad_right) begin
               left  = s;
               right = -s;
            end else begin
               left  = 0;
               right = 0;
            end
         end
         // button toggles affect driving from the next request only
         gap = p.now_ms - last_invert_ms;
         if (p.invert_button && gap > 32'(debounce_ms)) begin
            drive_reversed  = !drive_reversed;
            weapon_reversed = !weapon_reversed;
            last_invert_ms  = p.now_ms;
            reversals++;
         end
         gap = p.now_ms - last_weapon_ms;
         if (p.weapon_button && gap > 32'(debounce_ms)) begin
            weapon_on      = !weapon_on;
            last_weapon_ms = p.now_ms;
            weapon_toggles++;
         end
         cmd.left_mode   = mode_of(left);
         cmd.right_mode  = mode_of(right);
         cmd.left_duty   = duty_of(left);
         cmd.right_duty  = duty_of(right);
         cmd.weapon_a    = weapon_on && weapon_reversed;
         cmd.weapon_b    = weapon_on && !weapon_reversed;
         cmd.weapon_duty = weapon_on ? weapon_speed : 8'd0;
         pending_cmds.push_back(cmd);
      endfunction

      function void check_result(bridge_cmd_type got);
         bridge_cmd_type want;
         if (pending_cmds.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected bridge command with no request pending");
            return;
         end
         want = pending_cmds.pop_front();
         checked++;
         if (got.left_mode !== want.left_mode || got.right_mode !== want.right_mode ||
             got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
             got.weapon_a !== want.weapon_a || got.weapon_b !== want.weapon_b ||
             got.weapon_duty !== want.weapon_duty) begin
            errors++;
            if (errors <= 10) begin
               $display("command %0d mismatch: exp mode %0d/%0d duty %0d/%0d weapon %b%b %0d",
                        checked, want.left_mode, want.right_mode, want.left_duty,
                        want.right_duty, want.weapon_a, want.weapon_b, want.weapon_duty);
               $display("                       got mode %0d/%0d duty %0d/%0d weapon %b%b %0d",
                        got.left_mode, got.right_mode, got.left_duty, got.right_duty,
                        got.weapon_a, got.weapon_b, got.weapon_duty);
            end
         end
      endfunction

      function int pending();
         return pending_cmds.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   csr_index_type     csr_index = CSR_WEAPON_SPEED;
   logic [15:0]       csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic signed [3:0] req_stick_x = '0;
   logic signed [3:0] req_stick_y = '0;
   logic              req_stick_active = 1'b0;
   logic              req_pad_up = 1'b0;
   logic              req_pad_down = 1'b0;
   logic              req_pad_left = 1'b0;
   logic              req_pad_right = 1'b0;
   logic              req_invert_button = 1'b0;
   logic              req_weapon_button = 1'b0;
   logic [31:0]       req_now_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_left_mode;
   logic [1:0]        rsp_right_mode;
   logic [7:0]        rsp_left_duty;
   logic [7:0]        rsp_right_duty;
   logic              rsp_weapon_a;
   logic              rsp_weapon_b;
   logic [7:0]        rsp_weapon_duty;

   drive_scoreboard_type sb = new();
   int              cycle_count = 0;
   int              stall_left = 0;
   int              stall_pct = 20;
   int              gap_pct = 20;
   bit              quiet = 0;
   logic [31:0]     ms_now = '0;

   differential_drive_mixer_top #(
      .FULL_SPEED(FULL_SPEED),
      .AXIS_RANGE(AXIS_RANGE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_stick_x(req_stick_x),
      .req_stick_y(req_stick_y),
      .req_stick_active(req_stick_active),
      .req_pad_up(req_pad_up),
      .req_pad_down(req_pad_down),
      .req_pad_left(req_pad_left),
      .req_pad_right(req_pad_right),
      .req_invert_button(req_invert_button),
      .req_weapon_button(req_weapon_button),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_mode(rsp_left_mode),
      .rsp_right_mode(rsp_right_mode),
      .rsp_left_duty(rsp_left_duty),
      .rsp_right_duty(rsp_right_duty),
      .rsp_weapon_a(rsp_weapon_a),
      .rsp_weapon_b(rsp_weapon_b),
      .rsp_weapon_duty(rsp_weapon_duty)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d commands outstanding", cycle_count, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
         stall_left <= $urandom_range(4);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      bridge_cmd_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.left_mode   = rsp_left_mode;
         got.right_mode  = rsp_right_mode;
         got.left_duty   = rsp_left_duty;
         got.right_duty  = rsp_right_duty;
         got.weapon_a    = rsp_weapon_a;
         got.weapon_b    = rsp_weapon_b;
         got.weapon_duty = rsp_weapon_duty;
         sb.check_result(got);
      end
   end

   task send_poll(drive_poll_type p);
      req_stick_x       <= p.stick_x;
      req_stick_y       <= p.stick_y;
      req_stick_active  <= p.stick_active;
      req_pad_up        <= p.pad_up;
      req_pad_down      <= p.pad_down;
      req_pad_left      <= p.pad_left;
      req_pad_right     <= p.pad_right;
      req_invert_button <= p.invert_button;
      req_weapon_button <= p.weapon_button;
      req_now_ms        <= p.now_ms;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(p);
   endtask

   task maybe_pause();
      int n;
      if (!quiet && $urandom_range(99) < gap_pct) begin
         n = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // drain every outstanding command before touching the registers
   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_csr(csr_index_type idx, logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_register(idx, value);
      @(posedge clock);
   endtask

   function automatic drive_poll_type make_poll(int sx, int sy, bit act, bit [3:0] pads,
                                                bit inv, bit wpn, logic [31:0] ms);
      drive_poll_type p;
      p.stick_x       = 4'(sx);
      p.stick_y       = 4'(sy);
      p.stick_active  = act;
      p.pad_up        = pads[3];
      p.pad_down      = pads[2];
      p.pad_left      = pads[1];
      p.pad_right     = pads[0];
      p.invert_button = inv;
      p.weapon_button = wpn;
      p.now_ms        = ms;
      return p;
   endfunction

   // time mostly advances, with hits right on the debounce boundary
   function automatic drive_poll_type random_poll();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         ms_now = ms_now + 32'($urandom_range(0, 2 * int'(sb.debounce_ms) + 2));
      end else if (pick < 70) begin
         ms_now = sb.last_invert_ms + 32'(sb.debounce_ms) + 32'($urandom_range(1));
      end else if (pick < 80) begin
         ms_now = sb.last_weapon_ms + 32'(sb.debounce_ms) + 32'($urandom_range(1));
      end else if (pick >= 88) begin
         ms_now = $urandom();
      end
      return make_poll($urandom_range(15) - 8, $urandom_range(15) - 8, $urandom_range(1),
                       ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15)),
                       $urandom_range(99) < 30, $urandom_range(99) < 30, ms_now);
   endfunction

   initial begin
      int          ph;
      int          k;
      logic [15:0] speed;
      logic [15:0] deb;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // d-pad priorities
      send_poll(make_poll(0, 0, 0, 4'b0000, 0, 0, 32'd0));
      send_poll(make_poll(0, 0, 0, 4'b1000, 0, 0, 32'd10));
      send_poll(make_poll(0, 0, 0, 4'b0100, 0, 0, 32'd11));
      send_poll(make_poll(0, 0, 0, 4'b0010, 0, 0, 32'd12));
      maybe_pause();
      send_poll(make_poll(0, 0, 0, 4'b0001, 0, 0, 32'd13));
      send_poll(make_poll(0, 0, 0, 4'b1111, 0, 0, 32'd14));
      send_poll(make_poll(0, 0, 0, 4'b0111, 0, 0, 32'd15));
      // stick centered still selects joystick mode
      send_poll(make_poll(0, 0, 1, 4'b1111, 0, 0, 32'd16));
      send_poll(make_poll(7, 7, 1, 4'b0000, 0, 0, 32'd17));
      send_poll(make_poll(-7, -7, 1, 4'b0000, 0, 0, 32'd18));
      maybe_pause();
      send_poll(make_poll(7, -7, 1, 4'b0000, 0, 0, 32'd19));
      send_poll(make_poll(-7, 7, 1, 4'b0000, 0, 0, 32'd20));
      send_poll(make_poll(-8, -8, 1, 4'b0000, 0, 0, 32'd21));
      send_poll(make_poll(-8, 7, 1, 4'b0000, 0, 0, 32'd22));
      send_poll(make_poll(3, -2, 1, 4'b0000, 0, 0, 32'd23));
      // presses too close to reset do not toggle
      send_poll(make_poll(0, 0, 0, 4'b0000, 1, 0, 32'd300));
      send_poll(make_poll(0, 0, 0, 4'b0000, 0, 1, 32'd300));
      // both buttons at once; driving still uses the old direction
      send_poll(make_poll(0, 0, 0, 4'b1000, 1, 1, 32'd301));
      send_poll(make_poll(0, 0, 0, 4'b1000, 0, 0, 32'd302));
      send_poll(make_poll(7, 7, 1, 4'b0000, 0, 0, 32'd303));
      send_poll(make_poll(0, 0, 0, 4'b0000, 0, 1, 32'd500));
      send_poll(make_poll(0, 0, 0, 4'b0001, 1, 1, 32'd602));
      // press time wrapping around
      send_poll(make_poll(0, 0, 0, 4'b0000, 1, 1, 32'hFFFF_FFFF));
      send_poll(make_poll(0, 0, 0, 4'b0000, 1, 1, 32'h0000_0010));
      send_poll(make_poll(0, 0, 0, 4'b1000, 0, 0, 32'h0000_0020));

      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               speed = 16'd0;
               deb   = 16'd0;
            end
            1: begin
               speed = 16'd255;
               deb   = 16'd65535;
            end
            2: begin
               speed = 16'd1;
               deb   = 16'd1;
            end
            default: begin
               speed = 16'($urandom_range(255));
               deb   = 16'($urandom_range(0, 1500));
            end
         endcase
         write_csr(CSR_WEAPON_SPEED, speed);
         write_csr(CSR_DEBOUNCE_MS, deb);
         if (ph == PHASES - 1) quiet = 1;
         ms_now = $urandom();
         for (k = 0; k < POLLS_PER_PHASE; k++) begin
            if (k % 64 == 0) begin
               gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 50);
               stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 50);
            end
            send_poll(random_poll());
            maybe_pause();
         end
      end
      settle();

      $display("covered %0d polls: %0d joystick, %0d d-pad, %0d drive reversals, %0d %s",
               sb.stick_polls + sb.pad_polls, sb.stick_polls, sb.pad_polls, sb.reversals,
               sb.weapon_toggles, "weapon toggles");
      $display("%0d commands checked over %0d register settings, %0d errors",
               sb.checked, PHASES + 1, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### files.f
+incdir+rtl
rtl/ddm_pkg.sv
rtl/ddm_mix.sv
rtl/differential_drive_mixer_top.sv
sim/tb_top.sv
